/* hdl/audt_pkg.sv */
// Package for the angle unwrap and deadband tracker.
// Holds turn constants, configuration codes and the unwrap result struct.
// No dependencies.
`timescale 1ns / 1ps

package audt_pkg;

	// One full turn in tenths of a degree.
	localparam int unsigned FULL_TURN   = 3600;
	localparam int unsigned QUARTER     = FULL_TURN / 4;
	localparam int unsigned THREE_QUART = (3 * FULL_TURN) / 4;

	// 2^32 reduced modulo one turn. A wrap of the 32-bit offset shifts the
	// residue of its signed value by this amount.
	localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
	localparam int unsigned WRAP_RES   = int'(TWO_POW_32 % 33'(FULL_TURN));

	localparam int ANGLE_W = 12;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 16;
	localparam int CAL_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION_ANGLE = 2'd2;

	localparam logic [ANGLE_W-1:0] RADIUS_RESET = 12'd10;
	localparam logic [CNT_W-1:0]   SETTLE_RESET = 16'd666;

	typedef struct packed {
		logic [WORD_W-1:0]  unwrapped;   // raw plus turn offset, two's complement
		logic [ANGLE_W-1:0] residue;     // floor residue of its signed value
	} unwrap_res_t;

endpackage

/* hdl/audt_unwrap.sv */
// Seam unwrapper: keeps the turn offset and the residue of the last sample.
// Depends on audt_pkg.
`timescale 1ns / 1ps

module audt_unwrap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [audt_pkg::ANGLE_W-1:0] raw_angle,
	output audt_pkg::unwrap_res_t        res
);

	localparam logic [audt_pkg::WORD_W-1:0] TURN_W = audt_pkg::WORD_W'(audt_pkg::FULL_TURN);
	localparam logic [13:0] TURN_14 = 14'(audt_pkg::FULL_TURN);
	localparam logic [13:0] WRAP_14 = 14'(audt_pkg::WRAP_RES);
	localparam logic [13:0] QUART_14 = 14'(audt_pkg::QUARTER);
	localparam logic [13:0] THREE_14 = 14'(audt_pkg::THREE_QUART);

	logic                         first_q;
	logic [audt_pkg::WORD_W-1:0]  offset_q;
	logic [audt_pkg::ANGLE_W-1:0] off_res_q;   // floor residue of the signed offset
	logic [audt_pkg::ANGLE_W-1:0] last_res_q;  // floor residue of the last unwrapped value

	logic [13:0] raw_x, last_x, off_x;
	logic        go_down, go_up;
	logic [audt_pkg::WORD_W-1:0] offset_d;
	logic [13:0] off_res_d;
	logic [audt_pkg::WORD_W-1:0] sum;
	logic        sum_ovf;
	logic [13:0] acc0, acc1, acc2;

	assign raw_x  = 14'(raw_angle);
	assign last_x = 14'(last_res_q);
	assign off_x  = 14'(off_res_q);

	// The truncated and floor residues give the same seam decisions, so the
	// floor residue is all that is kept of the last sample.
	assign go_down = !first_q && (last_x <= QUART_14) && (raw_x > THREE_14);
	assign go_up   = !first_q && !go_down && (last_x >= THREE_14) && (raw_x < QUART_14);

	always_comb begin
		offset_d  = offset_q;
		off_res_d = off_x;
		if (go_up) begin
			offset_d = offset_q + TURN_W;
			// Signed overflow drops the value by 2^32.
			if (!offset_q[audt_pkg::WORD_W-1] && offset_d[audt_pkg::WORD_W-1]) begin
				off_res_d = (off_x >= WRAP_14) ? off_x - WRAP_14 : off_x + TURN_14 - WRAP_14;
			end
		end else if (go_down) begin
			offset_d = offset_q - TURN_W;
			if (offset_q[audt_pkg::WORD_W-1] && !offset_d[audt_pkg::WORD_W-1]) begin
				off_res_d = (off_x + WRAP_14 >= TURN_14) ? off_x + WRAP_14 - TURN_14
					: off_x + WRAP_14;
			end
		end
	end

	always_comb begin
		sum     = offset_d + audt_pkg::WORD_W'(raw_angle);
		sum_ovf = !offset_d[audt_pkg::WORD_W-1] && sum[audt_pkg::WORD_W-1];
		acc0    = raw_x + off_res_d;
		if (sum_ovf) begin
			acc0 = acc0 + TURN_14 - WRAP_14;
		end
		acc1 = (acc0 >= TURN_14) ? acc0 - TURN_14 : acc0;
		acc2 = (acc1 >= TURN_14) ? acc1 - TURN_14 : acc1;
		if (first_q) begin
			res.unwrapped = audt_pkg::WORD_W'(raw_angle);
			res.residue   = raw_angle;
		end else begin
			res.unwrapped = sum;
			res.residue   = acc2[audt_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			offset_q   <= '0;
			off_res_q  <= '0;
			last_res_q <= '0;
		end else if (step) begin
			first_q    <= 1'b0;
			offset_q   <= offset_d;
			off_res_q  <= off_res_d[audt_pkg::ANGLE_W-1:0];
			last_res_q <= res.residue;
		end
	end

endmodule

/* hdl/angle_unwrap_deadband_tracker_unit.sv */
// Top level of the angle unwrap and deadband tracker.
// Depends on audt_pkg and audt_unwrap.
`timescale 1ns / 1ps

//  channel | signals                                   | direction
//  in      | in_valid, in_ready, raw_angle             | sink
//  out     | out_valid, out_ready, accepted,           | source
//          | filtered_angle, changed, calibrated_angle |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
// One transaction per cycle while the output is not stalled; a result appears
// in the cycle after its input is taken. The unwrap, the deadband window and
// the residue are one combinational pass into the result register.
// Reset restores the register defaults and the first-sample state.
// A stalled result holds in_ready low; otherwise input is taken every cycle.

module angle_unwrap_deadband_tracker_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [audt_pkg::ANGLE_W-1:0]       raw_angle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic [audt_pkg::ANGLE_W-1:0]       filtered_angle,
	output logic                               changed,
	output logic signed [audt_pkg::CAL_W-1:0]  calibrated_angle,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [audt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [audt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// One bit wider than an angle; holds the full turn of 3600.
	localparam logic [audt_pkg::ANGLE_W:0] TURN_A =
		(audt_pkg::ANGLE_W + 1)'(audt_pkg::FULL_TURN);

	logic [audt_pkg::ANGLE_W-1:0] radius_q;
	logic [audt_pkg::CNT_W-1:0]   settle_q;
	logic [audt_pkg::ANGLE_W-1:0] calib_q;

	logic                         moving_q;
	logic [audt_pkg::WORD_W-1:0]  window_q;
	logic [audt_pkg::CNT_W-1:0]   stable_q;
	logic [audt_pkg::ANGLE_W-1:0] held_q;

	logic                         out_valid_q;
	logic                         accepted_s1;
	logic [audt_pkg::ANGLE_W-1:0] filtered_s1;
	logic                         changed_s1;
	logic [audt_pkg::CAL_W-1:0]   calibrated_s1;

	logic take, in_range, step;
	audt_pkg::unwrap_res_t uw;

	logic [audt_pkg::WORD_W:0]    diff;
	logic [audt_pkg::WORD_W:0]    gap;
	logic [audt_pkg::WORD_W:0]    radius_x;
	logic                         moving_d;
	logic [audt_pkg::WORD_W-1:0]  window_d;
	logic [audt_pkg::CNT_W-1:0]   stable_d;
	logic [audt_pkg::ANGLE_W-1:0] held_d;

	assign in_ready  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign take      = in_valid && in_ready;
	assign in_range  = (audt_pkg::ANGLE_W + 1)'(raw_angle) < TURN_A;
	assign step      = take && in_range;

	audt_unwrap u_unwrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.raw_angle (raw_angle),
		.res       (uw)
	);

	always_comb begin
		diff = {uw.unwrapped[audt_pkg::WORD_W-1], uw.unwrapped}
			- {window_q[audt_pkg::WORD_W-1], window_q};
		gap = diff[audt_pkg::WORD_W] ? -diff : diff;
		radius_x = (audt_pkg::WORD_W + 1)'(radius_q);

		moving_d = moving_q;
		window_d = window_q;
		stable_d = stable_q;
		held_d   = held_q;
		if (moving_q) begin
			if (gap < radius_x) begin
				stable_d = (stable_q == '1) ? stable_q : stable_q + 1'b1;
			end else begin
				stable_d = '0;
			end
			moving_d = !(stable_d > settle_q);
			window_d = uw.unwrapped;
			held_d   = uw.residue;
		end else if (gap > radius_x) begin
			moving_d = 1'b1;
			window_d = uw.unwrapped;
			stable_d = '0;
			held_d   = uw.residue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= audt_pkg::RADIUS_RESET;
			settle_q <= audt_pkg::SETTLE_RESET;
			calib_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				audt_pkg::CFG_WINDOW_RADIUS: begin
					radius_q <= cfg_data[audt_pkg::ANGLE_W-1:0];
				end
				audt_pkg::CFG_SETTLE_COUNT: begin
					settle_q <= cfg_data;
				end
				audt_pkg::CFG_CALIBRATION_ANGLE: begin
					calib_q <= cfg_data[audt_pkg::ANGLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q <= 1'b0;
			window_q <= '0;
			stable_q <= '0;
			held_q   <= '0;
		end else if (step) begin
			moving_q <= moving_d;
			window_q <= window_d;
			stable_q <= stable_d;
			held_q   <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= take;
		end
	end

	// An ignored sample reports the current held angle and no change.
	always_ff @(posedge clk) begin
		if (take) begin
			accepted_s1   <= in_range;
			filtered_s1   <= in_range ? held_d : held_q;
			changed_s1    <= in_range && (held_d != held_q);
			calibrated_s1 <= {1'b0, (in_range ? held_d : held_q)} - {1'b0, calib_q};
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = accepted_s1;
	assign filtered_angle   = filtered_s1;
	assign changed          = changed_s1;
	assign calibrated_angle = calibrated_s1;

	a_held_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(audt_pkg::ANGLE_W + 1)'(held_q) < TURN_A)
		else $error("held angle left the turn range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while a result was stalled");

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted transaction produced no result");

	a_ignored_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !accepted_s1 |-> !changed_s1 && filtered_s1 == held_q)
		else $error("ignored sample reported a change");

endmodule
